FILE: rtl/core/i2cm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the I2C master bit sequencer.
// No dependencies; i2cm_front, i2cm_queue, i2cm_back and the top level refer to it by scoped names.
package i2cm_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 2;
	localparam logic [15:0] PHASE_TICKS_RST = 16'd4;

	typedef enum logic [2:0] {
		CMD_START   = 3'd0,
		CMD_RESTART = 3'd1,
		CMD_WRITE   = 3'd2,
		CMD_READ    = 3'd3,
		CMD_SACK    = 3'd4,
		CMD_RACK    = 3'd5,
		CMD_STOP    = 3'd6
	} cmd_t;

	// One classified tick as it waits between front and back.
	typedef struct packed {
		logic       start;       // tick carries a legal command
		logic [2:0] func;
		logic       load_shift;  // command preloads the shift register
		logic [7:0] shift_init;
		logic       sda;
	} tick_t;

	typedef struct packed {
		logic       scl_low;
		logic       sda_low;
		logic       busy_res;
		logic [7:0] rx_byte;
		logic       nack_seen;
		logic       done_res;
	} result_t;

endpackage

FILE: rtl/core/i2cm_if.sv
`timescale 1ns / 1ps
// Handshake channels of the I2C master bit sequencer: tick input and result output.
// Stand-alone; no package dependency.
interface i2cm_in_if;
	logic       valid;
	logic       ready;
	logic       cmd_valid;
	logic [2:0] func;
	logic [7:0] tx_byte;
	logic       ack_drive;
	logic       sda_in;

	modport source (output valid, cmd_valid, func, tx_byte, ack_drive, sda_in, input ready);
	modport sink   (input valid, cmd_valid, func, tx_byte, ack_drive, sda_in, output ready);
endinterface

interface i2cm_out_if;
	logic       valid;
	logic       ready;
	logic       scl_low;
	logic       sda_low;
	logic       busy_res;
	logic [7:0] rx_byte;
	logic       nack_seen;
	logic       done_res;

	modport source (output valid, scl_low, sda_low, busy_res, rx_byte, nack_seen, done_res,
		input ready);
	modport sink   (input valid, scl_low, sda_low, busy_res, rx_byte, nack_seen, done_res,
		output ready);
endinterface

FILE: rtl/core/i2cm_front.sv
`timescale 1ns / 1ps
// Front end: takes tick beats, decodes the command and shift preload.
// Depends on i2cm_pkg and i2cm_in_if.
module i2cm_front (
	i2cm_in_if.sink        req,
	input  logic           q_ready,
	output logic           q_push,
	output i2cm_pkg::tick_t q_data
);

	always_comb begin
		q_data            = '0;
		q_data.func       = req.func;
		q_data.sda        = req.sda_in;
		// func 7 is no command at all
		q_data.start      = req.cmd_valid && (req.func <= i2cm_pkg::CMD_STOP);
		case (req.func)
			i2cm_pkg::CMD_WRITE: begin
				q_data.load_shift = 1'b1;
				q_data.shift_init = req.tx_byte;
			end
			i2cm_pkg::CMD_READ: begin
				q_data.load_shift = 1'b1;
				q_data.shift_init = 8'h00;
			end
			i2cm_pkg::CMD_SACK: begin
				q_data.load_shift = 1'b1;
				q_data.shift_init = {7'd0, req.ack_drive};
			end
			default: begin
				q_data.load_shift = 1'b0;
				q_data.shift_init = 8'h00;
			end
		endcase
	end

	assign req.ready = q_ready;
	assign q_push    = req.valid && q_ready;

endmodule

FILE: rtl/core/i2cm_queue.sv
`timescale 1ns / 1ps
// Short FIFO of decoded ticks between front and back.
// Depends on i2cm_pkg.
module i2cm_queue #(
	parameter int unsigned DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  i2cm_pkg::tick_t push_data,
	output logic            push_ready,
	input  logic            pop,
	output logic            pop_valid,
	output i2cm_pkg::tick_t pop_data
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	i2cm_pkg::tick_t        mem_q [DEPTH];
	logic [PW-1:0]          wr_ptr_q;
	logic [PW-1:0]          rd_ptr_q;
	logic [CW-1:0]          count_q;
	logic                   do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: rtl/core/i2cm_back.sv
`timescale 1ns / 1ps
// Back end: bus phase sequencer, phase tick counter and result register.
// Depends on i2cm_pkg and i2cm_out_if.
module i2cm_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [15:0]     cfg_wdata,
	input  logic            q_valid,
	input  i2cm_pkg::tick_t q_data,
	output logic            q_pop,
	i2cm_out_if.source      rsp
);

	function automatic logic [4:0] phase_total(input logic [2:0] cmd);
		case (cmd)
			i2cm_pkg::CMD_START:   phase_total = 5'd3;
			i2cm_pkg::CMD_RESTART: phase_total = 5'd4;
			i2cm_pkg::CMD_WRITE:   phase_total = 5'd17;
			i2cm_pkg::CMD_READ:    phase_total = 5'd17;
			i2cm_pkg::CMD_SACK:    phase_total = 5'd3;
			i2cm_pkg::CMD_RACK:    phase_total = 5'd3;
			i2cm_pkg::CMD_STOP:    phase_total = 5'd3;
			default:               phase_total = 5'd0;
		endcase
	endfunction

	// Line levels of a phase as {scl_low, sda_low}.
	function automatic logic [1:0] phase_lines(input logic [2:0] cmd, input logic [4:0] s,
		input logic [7:0] sh);
		logic c;
		logic d;
		c = 1'b1;
		d = 1'b0;
		case (cmd)
			i2cm_pkg::CMD_START: begin
				c = (s == 5'd2);
				d = (s != 5'd0);
			end
			i2cm_pkg::CMD_RESTART: begin
				c = (s == 5'd0) || (s == 5'd3);
				d = (s >= 5'd2);
			end
			i2cm_pkg::CMD_WRITE: begin
				if (s < 5'd16) begin
					c = ~s[0];
					d = ~sh[7];
				end
			end
			i2cm_pkg::CMD_READ: begin
				c = (s < 5'd16) ? ~s[0] : 1'b1;
			end
			i2cm_pkg::CMD_SACK: begin
				c = (s != 5'd1);
				d = sh[0];
			end
			i2cm_pkg::CMD_RACK: begin
				c = (s != 5'd1);
			end
			i2cm_pkg::CMD_STOP: begin
				c = (s == 5'd0);
				d = (s != 5'd2);
			end
			default: begin
				c = 1'b1;
				d = 1'b0;
			end
		endcase
		phase_lines = {c, d};
	endfunction

	logic [15:0] phase_ticks_q;
	logic [2:0]  cmd_q;
	logic [4:0]  step_q;
	logic [15:0] tick_q;
	logic [7:0]  shift_q;
	logic [7:0]  rx_q;
	logic        ack_q;
	logic        busy_q;
	logic        scl_q;
	logic        sda_q;

	logic        out_valid_q;
	i2cm_pkg::result_t out_q;

	logic [2:0]  cmd_d;
	logic [4:0]  step_d;
	logic [15:0] tick_d;
	logic [7:0]  shift_d;
	logic [7:0]  rx_d;
	logic        ack_d;
	logic        busy_d;
	logic        scl_d;
	logic        sda_d;
	logic        done_d;
	logic [16:0] tick_inc;
	logic [15:0] limit;
	logic [1:0]  lines;

	assign q_pop = q_valid && (!out_valid_q || rsp.ready);

	always_comb begin
		cmd_d    = cmd_q;
		step_d   = step_q;
		tick_d   = tick_q;
		shift_d  = shift_q;
		rx_d     = rx_q;
		ack_d    = ack_q;
		busy_d   = busy_q;
		scl_d    = scl_q;
		sda_d    = sda_q;
		done_d   = 1'b0;
		lines    = 2'b00;
		limit    = (phase_ticks_q == 16'd0) ? 16'd1 : phase_ticks_q;
		tick_inc = {1'b0, tick_q} + 17'd1;
		if (busy_q) begin
			if (tick_inc >= {1'b0, limit}) begin
				// phase ends: shift or sample first, then move on
				if (cmd_q == i2cm_pkg::CMD_WRITE && step_q < 5'd16 && step_q[0]) begin
					shift_d = {shift_q[6:0], 1'b0};
				end else if (cmd_q == i2cm_pkg::CMD_READ && step_q < 5'd16 && step_q[0]) begin
					shift_d = {shift_q[6:0], q_data.sda};
					if (step_q == 5'd15) begin
						rx_d = shift_d;
					end
				end else if (cmd_q == i2cm_pkg::CMD_RACK && step_q == 5'd1) begin
					ack_d = q_data.sda;
				end
				tick_d = 16'd0;
				step_d = step_q + 5'd1;
				if (step_d >= phase_total(cmd_q)) begin
					busy_d = 1'b0;
					done_d = 1'b1;
				end else begin
					lines = phase_lines(cmd_q, step_d, shift_d);
					scl_d = lines[1];
					sda_d = lines[0];
				end
			end else begin
				tick_d = tick_inc[15:0];
			end
		end else if (q_data.start) begin
			cmd_d  = q_data.func;
			step_d = 5'd0;
			tick_d = 16'd0;
			if (q_data.load_shift) begin
				shift_d = q_data.shift_init;
			end
			busy_d = 1'b1;
			lines  = phase_lines(q_data.func, 5'd0, shift_d);
			scl_d  = lines[1];
			sda_d  = lines[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= i2cm_pkg::PHASE_TICKS_RST;
			cmd_q         <= '0;
			step_q        <= '0;
			tick_q        <= '0;
			shift_q       <= '0;
			rx_q          <= '0;
			ack_q         <= 1'b0;
			busy_q        <= 1'b0;
			scl_q         <= 1'b0;
			sda_q         <= 1'b0;
			out_valid_q   <= 1'b0;
			out_q         <= '0;
		end else begin
			if (cfg_we) begin
				phase_ticks_q <= cfg_wdata;
			end
			if (q_pop) begin
				cmd_q   <= cmd_d;
				step_q  <= step_d;
				tick_q  <= tick_d;
				shift_q <= shift_d;
				rx_q    <= rx_d;
				ack_q   <= ack_d;
				busy_q  <= busy_d;
				scl_q   <= scl_d;
				sda_q   <= sda_d;
				out_q.scl_low   <= scl_d;
				out_q.sda_low   <= sda_d;
				out_q.busy_res  <= busy_d;
				out_q.rx_byte   <= rx_d;
				out_q.nack_seen <= ack_d;
				out_q.done_res  <= done_d;
				out_valid_q     <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.scl_low   = out_q.scl_low;
	assign rsp.sda_low   = out_q.sda_low;
	assign rsp.busy_res  = out_q.busy_res;
	assign rsp.rx_byte   = out_q.rx_byte;
	assign rsp.nack_seen = out_q.nack_seen;
	assign rsp.done_res  = out_q.done_res;

endmodule

FILE: rtl/core/i2c_master_bit_sequencer.sv
`timescale 1ns / 1ps
// I2C master bit sequencer, top level: front decoder, tick queue, phase sequencer.
// A result beat is offered from the result register after its tick beat has passed the queue.
// Throughput: one tick beat per cycle while the queue has room; the sequencer state updates once per tick.
// The queue holds QUEUE_DEPTH ticks while the result side stalls.
// Reset (arst_n low, asynchronous): lines released, idle, phase_ticks back to 4.
module i2c_master_bit_sequencer #(
	parameter int unsigned QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	i2cm_in_if.sink     req,
	i2cm_out_if.source  rsp
);

	logic            push;
	logic            push_ready;
	i2cm_pkg::tick_t push_data;
	logic            pop;
	logic            pop_valid;
	i2cm_pkg::tick_t pop_data;

	i2cm_front u_front (
		.req     (req),
		.q_ready (push_ready),
		.q_push  (push),
		.q_data  (push_data)
	);

	i2cm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data)
	);

	i2cm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (pop_valid),
		.q_data    (pop_data),
		.q_pop     (pop),
		.rsp       (rsp)
	);

endmodule

FILE: rtl/core/i2cm_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the I2C master bit sequencer, bound to the top level.
// Depends on i2c_master_bit_sequencer and the channel interfaces.
module i2cm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       scl_low,
	input logic       sda_low,
	input logic       busy_res,
	input logic [7:0] rx_byte,
	input logic       nack_seen,
	input logic       done_res
);

	// a finished command is never reported busy
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && done_res |-> !busy_res)
		else $error("done beat reports busy");

	// the queue only backs up behind a held result
	a_full_needs_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid)
		else $error("input stalled with no result waiting");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(scl_low) && $stable(sda_low)
			&& $stable(busy_res) && $stable(rx_byte) && $stable(nack_seen)
			&& $stable(done_res))
		else $error("stalled result beat changed");

endmodule

bind i2c_master_bit_sequencer i2cm_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.scl_low   (rsp.scl_low),
	.sda_low   (rsp.sda_low),
	.busy_res  (rsp.busy_res),
	.rx_byte   (rsp.rx_byte),
	.nack_seen (rsp.nack_seen),
	.done_res  (rsp.done_res)
);
